>>> hdl/iidl_pkg.sv
`default_nettype none

package iidl_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int POS_W            = 7;
  localparam int DATA_W           = 32;
  localparam int GROUP_SIZE       = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE
  } state_t;

  typedef struct packed {
    logic               ins;
    logic               del;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  wval;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/iidl_cell.sv
`default_nettype none

module iidl_cell #(
  parameter int INDEX = 0,
  parameter int CW    = iidl_pkg::POS_W
) (
  input  wire logic                        clk,
  input  wire iidl_pkg::cell_ctrl_t        ctrl,
  input  wire logic [iidl_pkg::DATA_W-1:0] lower_value,
  input  wire logic [iidl_pkg::DATA_W-1:0] upper_value,
  output logic      [iidl_pkg::DATA_W-1:0] value,
  output logic      [iidl_pkg::DATA_W-1:0] sel_value
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [CW-1:0] pos_ext;

  assign pos_ext   = CW'(ctrl.pos);
  assign sel_value = (pos_ext == IDX) ? value : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX == pos_ext) begin
        value <= ctrl.wval;
      end else if (IDX > pos_ext) begin
        value <= lower_value;
      end
    end else if (ctrl.del && (IDX >= pos_ext)) begin
      value <= upper_value;
    end
  end

endmodule

`default_nettype wire

>>> hdl/indexed_insert_delete_list_core.sv
// Channel | Signals                                  | Direction
// request | start, busy, req_type, position,         | in (busy out)
//         | write_value                              |
// result  | done, status, read_value, entry_count    | out
//
// A request is taken when start is high and busy is low; it passes through the
// EXEC and REDUCE states, and its result appears with done as busy drops.
// EXEC applies the shift or write in the cell row; EXEC and REDUCE select
// the read word through a registered OR tree of groups of eight cells.
// Reset clears the count and the control state; the stored words are kept.
// The receiver cannot stall, so done lasts exactly one cycle.
`default_nettype none

module indexed_insert_delete_list_core #(
  parameter int CAPACITY = iidl_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         req_type,
  input  wire logic [iidl_pkg::POS_W-1:0]         position,
  input  wire logic signed [iidl_pkg::DATA_W-1:0] write_value,
  output logic                                    done,
  output logic [1:0]                              status,
  output logic signed [iidl_pkg::DATA_W-1:0]      read_value,
  output logic [iidl_pkg::POS_W-1:0]              entry_count
);

  localparam int CW = ($clog2(CAPACITY + 1) > iidl_pkg::POS_W) ?
                      $clog2(CAPACITY + 1) : iidl_pkg::POS_W;
  localparam int NG = (CAPACITY + iidl_pkg::GROUP_SIZE - 1) / iidl_pkg::GROUP_SIZE;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  iidl_pkg::state_t state, state_next;
  iidl_pkg::req_t   req;
  logic [iidl_pkg::POS_W-1:0]  pos;
  logic [iidl_pkg::DATA_W-1:0] wval;
  logic [CW-1:0]               count, count_next;
  iidl_pkg::status_t           stat, stat_next;
  logic                        get_ok, get_ok_next;
  logic                        exec_en, reduce_en, accept;
  logic [CW-1:0]               pos_ext;
  iidl_pkg::cell_ctrl_t        ctrl;

  logic [iidl_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [iidl_pkg::DATA_W-1:0] sel_pad    [NG*iidl_pkg::GROUP_SIZE];
  logic [iidl_pkg::DATA_W-1:0] grp        [NG];
  logic [iidl_pkg::DATA_W-1:0] grp_next   [NG];
  logic [iidl_pkg::DATA_W-1:0] read_next;

  assign accept  = start && !busy;
  assign pos_ext = CW'(pos);

  always_comb begin
    state_next = state;
    case (state)
      iidl_pkg::ST_IDLE:   if (start) state_next = iidl_pkg::ST_EXEC;
      iidl_pkg::ST_EXEC:   state_next = iidl_pkg::ST_REDUCE;
      iidl_pkg::ST_REDUCE: state_next = iidl_pkg::ST_IDLE;
      default:             state_next = iidl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    exec_en   = 1'b0;
    reduce_en = 1'b0;
    case (state)
      iidl_pkg::ST_IDLE:   busy = 1'b0;
      iidl_pkg::ST_EXEC:   exec_en = 1'b1;
      iidl_pkg::ST_REDUCE: reduce_en = 1'b1;
      default:             busy = 1'b0;
    endcase
  end

  always_comb begin
    count_next  = count;
    stat_next   = iidl_pkg::STAT_OK;
    get_ok_next = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.pos    = pos;
    ctrl.wval   = wval;
    case (req)
      iidl_pkg::REQ_INSERT: begin
        if (pos_ext > count) begin
          stat_next = iidl_pkg::STAT_BAD_POS;
        end else if (count >= CAP_C) begin
          stat_next = iidl_pkg::STAT_FULL;
        end else begin
          count_next = count + CW'(1);
          ctrl.ins   = exec_en;
        end
      end
      iidl_pkg::REQ_GET: begin
        if (pos_ext >= count) begin
          stat_next = iidl_pkg::STAT_BAD_POS;
        end else begin
          get_ok_next = 1'b1;
        end
      end
      iidl_pkg::REQ_DELETE: begin
        if (pos_ext >= count) begin
          stat_next = iidl_pkg::STAT_BAD_POS;
        end else begin
          count_next = count - CW'(1);
          ctrl.del   = exec_en;
        end
      end
      iidl_pkg::REQ_CLEAR: count_next = '0;
      default:             count_next = count;
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [iidl_pkg::DATA_W-1:0] lower_in, upper_in;
    if (k == 0) begin : g_first
      assign lower_in = '0;
    end else begin : g_mid_lo
      assign lower_in = cell_value[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign upper_in = '0;
    end else begin : g_mid_hi
      assign upper_in = cell_value[k+1];
    end
    iidl_cell #(
      .INDEX(k),
      .CW   (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .lower_value(lower_in),
      .upper_value(upper_in),
      .value      (cell_value[k]),
      .sel_value  (sel_pad[k])
    );
  end

  for (genvar k = CAPACITY; k < NG*iidl_pkg::GROUP_SIZE; k++) begin : g_pad
    assign sel_pad[k] = '0;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < iidl_pkg::GROUP_SIZE; j++) begin
        grp_next[g] = grp_next[g] | sel_pad[g*iidl_pkg::GROUP_SIZE + j];
      end
    end
  end

  always_comb begin
    read_next = '0;
    for (int g = 0; g < NG; g++) begin
      read_next = read_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iidl_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= reduce_en;
      if (exec_en) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= iidl_pkg::req_t'(req_type);
      pos  <= position;
      wval <= write_value;
    end
    if (exec_en) begin
      stat   <= stat_next;
      get_ok <= get_ok_next;
      grp    <= grp_next;
    end
    if (reduce_en) begin
      status      <= stat;
      read_value  <= get_ok ? read_next : '0;
      entry_count <= count[iidl_pkg::POS_W-1:0];
    end
  end

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 busy ##1 done)
    else $error("request did not complete in three cycles");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == iidl_pkg::STAT_OK || status == iidl_pkg::STAT_BAD_POS ||
              status == iidl_pkg::STAT_FULL))
    else $error("undefined status code");

endmodule

`default_nettype wire
